/* rtl/lms3_pkg.sv */
package lms3_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS       = 32;
  localparam int OUT_ROW_BITS      = 12;
  localparam int OUT_COL_BITS      = 10;
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 13;

  // configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // item command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
  } pix_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] kept_value;
    logic [OUT_ROW_BITS-1:0]       out_row;
    logic [OUT_COL_BITS-1:0]       out_col;
    logic                          frame_last;
  } res_t;

  // one shift step handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic                          emit;
    logic                          has_up;
    logic                          has_down;
    logic                          has_left;
    logic                          has_right;
    logic                          last;
    logic [OUT_ROW_BITS-1:0]       row;
    logic [OUT_COL_BITS-1:0]       col;
  } op_t;

endpackage

/* rtl/local_maximum_suppression_3x3_top.sv */
// 3x3 local-maximum suppression over a raster stream of corner responses
//
// pix channel (pix_valid / pix_stall / pix): one item per sample in raster
//   order; cmd = drain pushes one pending result out after the frame end
// res channel (res_valid / res_stall / res): one item per pixel, holding the
//   pixel value when it is a positive local maximum of its in-frame 3x3
//   neighbourhood (ties kept), otherwise zero, with its row, column and a
//   frame_last flag on the final pixel
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): frame_width and
//   frame_height, clamped to 1..max; a write restarts the frame, always ready
// throughput: one item per clock while res is not stalled; each line store is read as an item leaves
//   the queue and written one stage later, with a forward for single-column
//   frames, so nothing limits the rate below one
// output order: res_valid rises once the item completing a pixel's neighbourhood
//   (width + 1 items after the pixel) has passed the queue, the stage-a register
//   and the output register, which is why width + 1 drains are needed after the last sample
// a stalled res item waits in the output register; the back end holds and
//   the four-item queue keeps taking pix items until it fills
// reset clears counters, window and sizes (640 x 480); the line stores
//   need no clearing pass
module local_maximum_suppression_3x3_top import lms3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  pix_t                      pix,
  output logic                      res_valid,
  input  logic                      res_stall,
  output res_t                      res
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int Q_WIDTH  = $bits(op_t) + COL_BITS;

  // front to queue
  op_t                 op;
  logic [COL_BITS-1:0] op_addr;
  logic                push, q_full, restart;

  // queue to back
  logic [Q_WIDTH-1:0]  q_head;
  logic                q_valid, pop;
  op_t                 q_op;
  logic [COL_BITS-1:0] q_addr;

  // front: sizes, raster position and emit position, classifies each item
  lms3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .q_full    (q_full),
    .push      (push),
    .op        (op),
    .op_addr   (op_addr),
    .restart   (restart)
  );

  // short queue so the front keeps going while the back waits on res
  lms3_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({op, op_addr}),
    .full       (q_full),
    .pop        (pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  assign q_op   = op_t'(q_head[Q_WIDTH-1:COL_BITS]);
  assign q_addr = q_head[COL_BITS-1:0];

  // back: line stores, 3x3 window, compare and output register
  lms3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_addr    (q_addr),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* rtl/lms3_front.sv */
module lms3_front import lms3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  pix_t                             pix,
  input  logic                             q_full,
  output logic                             push,
  output op_t                              op,
  output logic [$clog2(MAX_WIDTH)-1:0]     op_addr,
  output logic                             restart
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
  localparam int HGT_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);

  logic [WID_BITS-1:0] eff_w;
  logic [HGT_BITS-1:0] eff_h;
  logic [ROW_BITS-1:0] input_row;
  logic [COL_BITS-1:0] input_col;
  logic [HGT_BITS-1:0] emit_row;
  logic [COL_BITS-1:0] emit_col;

  logic accept, complete, is_drain, shift, col_end, warmup, emit, row_end, ecol_end;

  function automatic logic [WID_BITS-1:0] clamp_width(input logic [FRAME_WIDTH_BITS-1:0] x);
    logic [WID_BITS-1:0] r;
    if (x == '0) begin
      r = WID_BITS'(1);
    end else if (32'(x) > 32'(MAX_WIDTH)) begin
      r = WID_BITS'(MAX_WIDTH);
    end else begin
      r = WID_BITS'(x);
    end
    return r;
  endfunction

  function automatic logic [HGT_BITS-1:0] clamp_height(input logic [FRAME_HEIGHT_BITS-1:0] x);
    logic [HGT_BITS-1:0] r;
    if (x == '0) begin
      r = HGT_BITS'(1);
    end else if (32'(x) > 32'(MAX_HEIGHT)) begin
      r = HGT_BITS'(MAX_HEIGHT);
    end else begin
      r = HGT_BITS'(x);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign pix_stall = q_full;

  always_comb begin
    accept   = pix_valid && !pix_stall;
    complete = 32'(input_row) >= 32'(eff_h);
    is_drain = pix.cmd == CMD_DRAIN;
    // a drain before the frame is in does nothing
    shift    = accept && !(is_drain && !complete);
    col_end  = 32'(input_col) + 32'd1 >= 32'(eff_w);
    // first width + 1 steps of a frame fill the window only
    warmup   = input_row == '0 || (input_row == ROW_BITS'(1) && input_col == '0);
    emit     = !warmup;
    row_end  = 32'(emit_row) + 32'd1 >= 32'(eff_h);
    ecol_end = 32'(emit_col) + 32'd1 >= 32'(eff_w);
  end

  always_comb begin
    op.val       = complete ? '0 : pix.sample;
    op.emit      = emit;
    op.has_up    = emit_row != '0;
    op.has_down  = !row_end;
    op.has_left  = emit_col != '0;
    op.has_right = !ecol_end;
    op.last      = row_end && ecol_end;
    op.row       = OUT_ROW_BITS'(emit_row);
    op.col       = OUT_COL_BITS'(emit_col);
  end

  assign push    = shift;
  assign op_addr = input_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w     <= clamp_width(FRAME_WIDTH_RESET);
      eff_h     <= clamp_height(FRAME_HEIGHT_RESET);
      input_row <= '0;
      input_col <= '0;
      emit_row  <= '0;
      emit_col  <= '0;
    end else if (restart) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        eff_w <= clamp_width(cfg_data[FRAME_WIDTH_BITS-1:0]);
      end else begin
        eff_h <= clamp_height(cfg_data[FRAME_HEIGHT_BITS-1:0]);
      end
      input_row <= '0;
      input_col <= '0;
      emit_row  <= '0;
      emit_col  <= '0;
    end else if (shift) begin
      if (col_end) begin
        input_col <= '0;
        input_row <= input_row + ROW_BITS'(1);
      end else begin
        input_col <= input_col + COL_BITS'(1);
      end
      if (emit) begin
        if (row_end && ecol_end) begin
          // last pixel out: frame starts over
          input_row <= '0;
          input_col <= '0;
          emit_row  <= '0;
          emit_col  <= '0;
        end else if (ecol_end) begin
          emit_col <= '0;
          emit_row <= emit_row + HGT_BITS'(1);
        end else begin
          emit_col <= emit_col + COL_BITS'(1);
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_cols_in_frame: assert property (@(posedge clk) disable iff (rst)
    32'(input_col) < 32'(eff_w) && 32'(emit_col) < 32'(eff_w))
    else $error("column counter beyond frame width");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (push && op.emit && op.last) |=> (emit_row == '0 && emit_col == '0 && input_row == '0))
    else $error("counters not cleared after final pixel");
`endif

endmodule

/* rtl/lms3_queue.sv */
module lms3_queue import lms3_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             head_valid
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full       = count == CNT_BITS'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !head_valid))
    else $error("queue overrun or underrun");
`endif

endmodule

/* rtl/lms3_back.sv */
module lms3_back import lms3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic                         q_valid,
  input  op_t                          q_op,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output res_t                         res
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic signed [SAMPLE_BITS-1:0] upper_line  [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] middle_line [MAX_WIDTH];

  logic signed [SAMPLE_BITS-1:0] up_rd, mid_rd, byp_up, byp_mid, up_eff, mid_eff;
  logic                          valid_a, byp_a;
  op_t                           op_a;
  logic [COL_BITS-1:0]           addr_a;

  logic signed [SAMPLE_BITS-1:0] win      [3][3];
  logic signed [SAMPLE_BITS-1:0] win_next [3][3];
  logic signed [SAMPLE_BITS-1:0] center;
  logic                          row_ok [3];
  logic                          col_ok [3];
  logic                          keep, adv, wr_en;

  assign adv     = !res_valid || !res_stall;
  assign pop     = adv && q_valid;
  assign wr_en   = adv && valid_a;
  // step just before wrote the same column (single-column frames)
  assign up_eff  = byp_a ? byp_up  : up_rd;
  assign mid_eff = byp_a ? byp_mid : mid_rd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_line[addr_a]  <= mid_eff;
      middle_line[addr_a] <= op_a.val;
    end
    if (pop) begin
      up_rd  <= upper_line[q_addr];
      mid_rd <= middle_line[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_a    <= q_op;
      addr_a  <= q_addr;
      byp_a   <= valid_a && (q_addr == addr_a);
      byp_up  <= mid_eff;
      byp_mid <= op_a.val;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = up_eff;
    win_next[1][2] = mid_eff;
    win_next[2][2] = op_a.val;
  end

  // kept when positive and no in-frame neighbour is larger
  always_comb begin
    center    = win_next[1][1];
    row_ok[0] = op_a.has_up;
    row_ok[1] = 1'b1;
    row_ok[2] = op_a.has_down;
    col_ok[0] = op_a.has_left;
    col_ok[1] = 1'b1;
    col_ok[2] = op_a.has_right;
    keep      = !center[SAMPLE_BITS-1] && center != '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c] && win_next[r][c] > center) begin
          keep = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      valid_a   <= q_valid;
      res_valid <= valid_a && op_a.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (wr_en) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && op_a.emit) begin
      res.kept_value <= keep ? center : '0;
      res.out_row    <= op_a.row;
      res.out_col    <= op_a.col;
      res.frame_last <= op_a.last;
    end
  end

`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> (!wr_en && !pop))
    else $error("back end advanced while result stalled");
`endif

endmodule

/* tb/lms3_checker.sv */
`timescale 1ns / 1ps

module lms3_checker import lms3_pkg::*; #(
  parameter int MAX_W = 1024,
  parameter int MAX_H = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      pix_valid,
  input  logic                      pix_stall,
  input  pix_t                      pix,
  input  logic                      res_valid,
  input  logic                      res_stall,
  input  res_t                      res,
  output int                        pending,
  output int                        mismatches,
  output int                        items_seen,
  output int                        results_seen,
  output int                        maxima_seen,
  output int                        frames_seen
);

  // only the first few mismatch lines are printed, all are counted
  localparam int MAX_PRINTED = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  sample_t                      line_up [MAX_W];
  sample_t                      line_mid [MAX_W];
  sample_t                      win [9];
  logic [FRAME_WIDTH_BITS-1:0]  width_reg;
  logic [FRAME_HEIGHT_BITS-1:0] height_reg;
  int                           in_row, in_col, em_row, em_col;
  res_t                         expected_q [$];

  function automatic int size_in_use(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  task automatic restart_frame();
    in_row = 0;
    in_col = 0;
    em_row = 0;
    em_col = 0;
    foreach (win[i]) win[i] = '0;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] lms3 check: %s", $time, what);
  endtask

  // one shift step of the suppression window; at most one pixel result
  task automatic suppress_step(input pix_t item, output bit emits, output res_t out_item);
    int      w, h, col, n;
    bit      complete;
    bit      row_ok [3];
    bit      col_ok [3];
    sample_t v, best, centre;
    w = size_in_use(int'(width_reg), MAX_W);
    h = size_in_use(int'(height_reg), MAX_H);
    emits = 1'b0;
    out_item = '0;
    complete = (in_row >= h);
    col = (in_col < w) ? in_col : 0;
    n = in_row * w + col;
    // drains inside the frame are ignored, samples past its end act as drains
    if (item.cmd == CMD_SAMPLE || complete) begin
      v = complete ? sample_t'(0) : item.sample;
      for (int i = 0; i < 3; i++) begin
        win[3*i]   = win[3*i+1];
        win[3*i+1] = win[3*i+2];
      end
      win[2] = line_up[col];
      win[5] = line_mid[col];
      win[8] = v;
      line_up[col]  = line_mid[col];
      line_mid[col] = v;
      if (col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col = col + 1;
      end
      if (n >= w + 1) begin
        row_ok[0] = (em_row > 0);
        row_ok[1] = 1'b1;
        row_ok[2] = (em_row + 1 < h);
        col_ok[0] = (em_col > 0);
        col_ok[1] = 1'b1;
        col_ok[2] = (em_col + 1 < w);
        best = '0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (row_ok[i] && col_ok[j] && win[3*i+j] > best) best = win[3*i+j];
          end
        end
        centre = win[4];
        emits = 1'b1;
        out_item.kept_value = (centre == best) ? centre : '0;
        out_item.out_row    = OUT_ROW_BITS'(em_row);
        out_item.out_col    = OUT_COL_BITS'(em_col);
        out_item.frame_last = 1'b0;
        if (em_row + 1 >= h && em_col + 1 >= w) begin
          out_item.frame_last = 1'b1;
          in_row = 0;
          in_col = 0;
          em_row = 0;
          em_col = 0;
        end else if (em_col + 1 >= w) begin
          em_col = 0;
          em_row++;
        end else begin
          em_col++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    bit   emits;
    res_t predicted;
    res_t want;
    if (rst) begin
      foreach (line_up[i]) line_up[i] = '0;
      foreach (line_mid[i]) line_mid[i] = '0;
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      restart_frame();
      expected_q.delete();
      mismatches   = 0;
      items_seen   = 0;
      results_seen = 0;
      maxima_seen  = 0;
      frames_seen  = 0;
    end else begin
      // a write to a known register restarts the frame
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data[FRAME_WIDTH_BITS-1:0];
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data[FRAME_HEIGHT_BITS-1:0];
          restart_frame();
        end
      end
      if (pix_valid && !pix_stall) begin
        items_seen++;
        suppress_step(pix, emits, predicted);
        if (emits) expected_q.push_back(predicted);
      end
      if (res_valid && !res_stall) begin
        results_seen++;
        if (res.kept_value != 0) maxima_seen++;
        if (res.frame_last) frames_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result at (%0d,%0d) with none expected",
                                    res.out_row, res.out_col));
        end else begin
          want = expected_q.pop_front();
          if (res.kept_value !== want.kept_value)
            report_mismatch($sformatf("kept_value at (%0d,%0d): got %0d, want %0d",
                                      want.out_row, want.out_col, res.kept_value,
                                      want.kept_value));
          if (res.out_row !== want.out_row)
            report_mismatch($sformatf("out_row: got %0d, want %0d", res.out_row,
                                      want.out_row));
          if (res.out_col !== want.out_col)
            report_mismatch($sformatf("out_col: got %0d, want %0d", res.out_col,
                                      want.out_col));
          if (res.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last at (%0d,%0d): got %0b, want %0b",
                                      want.out_row, want.out_col, res.frame_last,
                                      want.frame_last));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lms3_pkg::*;

  localparam int     CLK_PERIOD    = 10;
  localparam int     RESET_CYCLES  = 9;
  localparam int     MAX_W         = 1024;
  localparam int     MAX_H         = 4096;
  // rough size of the random part, in items that reach the window
  localparam int     RANDOM_ITEMS  = 650;
  // rows sent of the single-column frame at the tallest height
  localparam int     TALL_ITEMS    = 160;
  // queue plus pipeline depth, enough for items that leave no result
  localparam int     SETTLE_CYCLES = 24;
  // in ns; many times the slowest legal run with the longest gaps and stalls
  localparam longint TIME_LIMIT    = 64'd40_000_000;

  // how the samples of one frame are drawn
  typedef enum int {
    FILL_FULL,     // any 32-bit value
    FILL_SMALL,    // -3..3, lots of ties
    FILL_SPARSE,   // low floor with the odd peak
    FILL_PLATEAU   // flat level with a few bumps and dips
  } fill_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      pix_valid = 1'b0;
  logic                      pix_stall;
  pix_t                      pix = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  res_t                      res;

  int pending, mismatches, items_seen, results_seen, maxima_seen, frames_seen;

  // sizes the block is using, as the stimulus sees them
  int cur_w, cur_h;
  int stream_items;
  int stall_left = 0;
  bit no_gaps = 1'b0;

  // directed 3x3 frame: both extremes, zero, a negative corner and a plateau of fives
  logic signed [SAMPLE_BITS-1:0] peak_grid [9] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000,
    32'sh8000_0000, 32'sh0000_0005, 32'sh0000_0005,
    32'shFFFF_FFFF, 32'sh0000_0005, 32'sh0000_0001
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  local_maximum_suppression_3x3_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  lms3_checker #(
    .MAX_W (MAX_W),
    .MAX_H (MAX_H)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pix          (pix),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .pending      (pending),
    .mismatches   (mismatches),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .maxima_seen  (maxima_seen),
    .frames_seen  (frames_seen)
  );

  // idle length: mostly short, now and then a long one
  function automatic int pause_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 92) return $urandom_range(3, 8);
    return $urandom_range(9, 30);
  endfunction

  // size the block will use once a register value is written
  function automatic int size_in_use(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input fill_t fill);
    case (fill)
      FILL_FULL: begin
        pick_sample = $urandom;
      end
      FILL_SMALL: begin
        pick_sample = $urandom_range(0, 6) - 3;
      end
      FILL_SPARSE: begin
        pick_sample = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1000)
                                                 : $urandom_range(0, 3);
      end
      default: begin
        if ($urandom_range(0, 7) != 0) pick_sample = 7;
        else pick_sample = $urandom_range(0, 1) ? 8 : -7;
      end
    endcase
  endfunction

  // result side: stall bursts of random length between runs of free flow,
  // some runs long enough to give stretches with no back-pressure at all
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (res_stall) begin
      res_stall  <= 1'b0;
      stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(60, 250)
                                                : $urandom_range(0, 12);
    end else begin
      res_stall  <= 1'b1;
      stall_left <= pause_len() - 1;
    end
  end

  // one pix item, after an optional gap; returns once it has been taken
  task automatic push_item(input logic cmd_i, input logic signed [SAMPLE_BITS-1:0] val);
    int gap;
    gap = (no_gaps || $urandom_range(0, 99) < 65) ? 0 : pause_len();
    @(negedge clk);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid  <= 1'b1;
    pix.cmd    <= cmd_i;
    pix.sample <= val;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  // stop sending, let every expected result out, then let the pipeline empty
  task automatic quiesce();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_DATA_BITS-1:0] wd,
                          input logic [CFG_DATA_BITS-1:0] hd);
    quiesce();
    write_reg(REG_FRAME_WIDTH, wd);
    write_reg(REG_FRAME_HEIGHT, hd);
    cur_w = size_in_use(int'(wd[FRAME_WIDTH_BITS-1:0]), MAX_W);
    cur_h = size_in_use(int'(hd[FRAME_HEIGHT_BITS-1:0]), MAX_H);
  endtask

  // a whole frame plus its width + 1 flush items; a broken frame stops
  // anywhere along the way and leaves the block mid-frame
  task automatic push_frame(input fill_t fill, input bit broken);
    int pixels, total, stop;
    pixels = cur_w * cur_h;
    total  = pixels + cur_w + 1;
    stop   = broken ? $urandom_range(0, total - 1) : total;
    for (int k = 0; k < stop; k++) begin
      if (k < pixels) begin
        // stray drain inside the frame, which the block must ignore
        if (!no_gaps && $urandom_range(0, 39) == 0) push_item(CMD_DRAIN, $urandom);
        push_item(CMD_SAMPLE, pick_sample(fill));
      end else if ($urandom_range(0, 5) == 0) begin
        // a sample past the frame end counts as a drain, its value unused
        push_item(CMD_SAMPLE, $urandom);
      end else begin
        push_item(CMD_DRAIN, $urandom);
      end
      stream_items++;
    end
  endtask

  initial begin : stimulus
    int                       which;
    bit                       broken;
    bit                       must_restart;
    logic [CFG_DATA_BITS-1:0] wd, hd;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed 3x3 frame: early drain, mid-frame drain, samples past the end
    set_size(16'd3, 16'd3);
    push_item(CMD_DRAIN, 32'sh1234_5678);
    for (int k = 0; k < 9; k++) begin
      push_item(CMD_SAMPLE, peak_grid[k]);
      if (k == 3) push_item(CMD_DRAIN, 32'sh0F0F_0F0F);
    end
    push_item(CMD_DRAIN, 32'sh0000_0000);
    push_item(CMD_SAMPLE, 32'sh5555_5555);
    push_item(CMD_DRAIN, 32'shFFFF_FFFF);
    push_item(CMD_DRAIN, 32'shAAAA_AAAA);

    // unknown register index: ignored, no restart
    quiesce();
    write_reg(4'hF, 16'hFFFF);

    // zero sizes with junk in the upper data bits clamp to a single pixel;
    // a negative lone pixel is suppressed, a positive one kept
    set_size(16'hF800, 16'hE000);
    push_item(CMD_SAMPLE, 32'shAAAA_AAAA);
    push_item(CMD_DRAIN, 32'sh0000_0000);
    push_item(CMD_DRAIN, 32'sh0000_0000);
    push_item(CMD_SAMPLE, 32'sh0000_0001);
    push_item(CMD_SAMPLE, 32'sh8000_0000);
    push_item(CMD_DRAIN, 32'sh7FFF_FFFF);

    // widest row (over-range width clamps to the maximum), one row, then
    // samples past its end that push out the first results of the row
    no_gaps = 1'b0;
    set_size(16'hFFFF, 16'd1);
    for (int k = 0; k < MAX_W + 40; k++) push_item(CMD_SAMPLE, pick_sample(FILL_FULL));

    // one column at the tallest height (over-range clamps), no sender gaps;
    // only its top part is sent, the random part restarts the frame
    no_gaps = 1'b1;
    set_size(16'd1, 16'hFFFF);
    for (int k = 0; k < TALL_ITEMS; k++) push_item(CMD_SAMPLE, pick_sample(FILL_SPARSE));

    // random part: mostly whole frames of small size, back to back or after a
    // resize, with the odd broken frame followed by a restart
    stream_items = 0;
    must_restart = 1'b1;
    while (stream_items < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if (must_restart || $urandom_range(0, 2) == 0) begin
        quiesce();
        if ($urandom_range(0, 5) == 0)
          write_reg(CFG_INDEX_BITS'($urandom_range(2, 15)), CFG_DATA_BITS'($urandom));
        // width only, height only, or both
        which = $urandom_range(0, 3);
        if (which != 1) begin
          case ($urandom_range(0, 9))
            0:       wd = '0;
            1:       wd = CFG_DATA_BITS'($urandom_range(13, 64));
            default: wd = CFG_DATA_BITS'($urandom_range(1, 12));
          endcase
          write_reg(REG_FRAME_WIDTH, wd);
          cur_w = size_in_use(int'(wd[FRAME_WIDTH_BITS-1:0]), MAX_W);
        end
        if (which != 0) begin
          case ($urandom_range(0, 9))
            0:       hd = '0;
            1:       hd = CFG_DATA_BITS'($urandom_range(9, 20));
            default: hd = CFG_DATA_BITS'($urandom_range(1, 8));
          endcase
          write_reg(REG_FRAME_HEIGHT, hd);
          cur_h = size_in_use(int'(hd[FRAME_HEIGHT_BITS-1:0]), MAX_H);
        end
        must_restart = 1'b0;
      end
      broken = ($urandom_range(0, 9) == 0);
      push_frame(fill_t'($urandom_range(0, 3)), broken);
      must_restart = broken;
    end

    // drain everything still owed, then give the verdict
    quiesce();
    $display("covered %0d items (%0d in the random part), %0d results of which %0d kept",
             items_seen, stream_items, results_seen, maxima_seen);
    $display("%0d complete frames up to 64 x 20, plus a %0d-wide row and a part-sent tall column",
             frames_seen, MAX_W);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(TIME_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
